/* sv/nsdq_pkg.sv */
package nsdq_pkg;

  // Channel and tap geometry
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned ChW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned EffW = $clog2(MaxChannels + 1);
  localparam int unsigned MaxTaps = 9;
  localparam int unsigned SetTaps = 9;
  localparam int unsigned UsedTaps = (MaxTaps < SetTaps) ? MaxTaps : SetTaps;
  localparam int unsigned NumGroups = (UsedTaps + 2) / 3;
  localparam int unsigned NumSets = 3;
  localparam int unsigned SetW = 2;

  // Field and register widths
  localparam int unsigned SampleW = 32;
  localparam int unsigned CodeW = 24;
  localparam int unsigned ModeW = 3;
  localparam int unsigned CntW = 4;
  localparam int unsigned CfgW = 4;
  localparam int unsigned CfgIdxW = 2;

  // Datapath widths, all in LSB units of the target word
  localparam int unsigned MW = 23;
  localparam int unsigned TapW = 20;
  localparam int unsigned CoefW = 16;
  localparam int unsigned CoefFrac = 14;
  localparam int unsigned FracBits = 16;
  localparam int unsigned XShift = 11;
  localparam int unsigned DitherW = 18;
  localparam int unsigned ProdW = TapW + CoefW;
  localparam int unsigned PSumW = ProdW + 2;
  localparam int unsigned AccW = PSumW + 2;
  localparam int unsigned FbW = AccW - CoefFrac;
  localparam int unsigned XProdW = SampleW + MW + 1;
  localparam int unsigned XRndW = XProdW - XShift;
  localparam int unsigned ShW = XRndW + 1;
  localparam int unsigned TotW = ShW + 1;
  localparam int unsigned FullW = MW + FracBits + 1;

  localparam logic [MW-1:0] M16 = MW'(32767);
  localparam logic [MW-1:0] M24 = MW'(8388607);
  localparam int ErrLimit = 524287;
  localparam logic [31:0] RngSeed = 32'h6d2b79f5;

  typedef enum logic [ModeW-1:0] {
    ModeTpdf     = 3'd0,
    ModeHighpass = 3'd1,
    ModeShaped5  = 3'd2,
    ModeShaped9  = 3'd3,
    ModeUltra    = 3'd4
  } dither_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDitherMode   = 2'd0,
    CfgWordLength24 = 2'd1,
    CfgChannelCount = 2'd2
  } cfg_idx_e;

  // Pipeline moves, all decided in the top level
  typedef struct packed {
    logic accept;
    logic move_b;
    logic move_c;
    logic move_d;
    logic move_o;
  } pipe_ctl_t;

  // Q2.14 feedback coefficients, one row per shaped mode
  localparam logic signed [CoefW-1:0] CoefTable [NumSets][SetTaps] = '{
    '{16'sd13435, -16'sd6226, 16'sd3113, -16'sd1311, 16'sd410,
      16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd15565, -16'sd8520, 16'sd5079, -16'sd2949, 16'sd1638,
      -16'sd852, 16'sd410, -16'sd164, 16'sd49},
    '{16'sd17695, -16'sd11141, 16'sd7537, -16'sd4915, 16'sd3113,
      -16'sd1802, 16'sd901, -16'sd360, 16'sd98}
  };

endpackage

/* sv/nsdq_ram.sv */
module nsdq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/nsdq_dither.sv */
module nsdq_dither (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nsdq_pkg::pipe_ctl_t                ctl_i,
  input  logic                               clear_i,
  input  logic                               highpass_i,
  input  logic [nsdq_pkg::ChW-1:0]           ch_i,
  output logic signed [nsdq_pkg::DitherW-1:0] dither_o
);
  import nsdq_pkg::*;

  localparam int unsigned DiffW = DitherW + 1;

  function automatic logic [31:0] xorshift32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    a = v ^ (v << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  logic [31:0]               rng_q, rng_d;
  logic [31:0]               r1, r2;
  logic signed [DitherW-1:0] d_acc;
  logic signed [DitherW-1:0] d_b_q;
  logic [MaxChannels-1:0]    pvld_q, pvld_d;
  logic                      pvld_b_q;
  logic [DitherW-1:0]        prior_rd;
  logic signed [DitherW-1:0] prior;
  logic signed [DiffW-1:0]   diff, diff_rnd;
  logic                      prior_we;

  // Two draws per transaction from the shared generator
  always_comb begin
    r1 = xorshift32(rng_q);
    r2 = xorshift32(r1);
    d_acc = $signed({2'b00, r1[31:16]}) - $signed({2'b00, r2[31:16]});
  end

  assign prior_we = ctl_i.accept && highpass_i;

  always_comb begin
    rng_d = rng_q;
    pvld_d = pvld_q;
    if (clear_i) begin
      rng_d = RngSeed;
      pvld_d = '0;
    end else if (ctl_i.accept) begin
      rng_d = r2;
      if (highpass_i) begin
        pvld_d[ch_i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q <= RngSeed;
      pvld_q <= '0;
    end else begin
      rng_q <= rng_d;
      pvld_q <= pvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      d_b_q <= d_acc;
      pvld_b_q <= pvld_q[ch_i];
    end
  end

  // Read the previous dither and, in high-pass mode, store the new one in the same cycle
  nsdq_ram #(
    .Width(DitherW),
    .Depth(MaxChannels)
  ) u_prior_ram (
    .clk_i  (clk_i),
    .we_i   (prior_we),
    .waddr_i(ch_i),
    .wdata_i(d_acc),
    .re_i   (ctl_i.accept),
    .raddr_i(ch_i),
    .rdata_o(prior_rd)
  );

  always_comb begin
    prior = pvld_b_q ? $signed(prior_rd) : '0;
    diff = DiffW'(d_b_q) - DiffW'(prior);
    diff_rnd = diff + (diff[DiffW-1] ? DiffW'(0) : DiffW'(1));
    dither_o = highpass_i ? $signed(diff_rnd[DiffW-1:1]) : d_b_q;
  end

endmodule

/* sv/nsdq_shaper.sv */
module nsdq_shaper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  nsdq_pkg::pipe_ctl_t                 ctl_i,
  input  logic                                clear_i,
  input  logic                                shaped_i,
  input  logic [nsdq_pkg::ModeW-1:0]          mode_i,
  input  logic [nsdq_pkg::MW-1:0]             m_i,
  input  logic [nsdq_pkg::ChW-1:0]            ch_i,
  input  logic [nsdq_pkg::ChW-1:0]            ch_e_i,
  input  logic signed [nsdq_pkg::SampleW-1:0] sample_i,
  input  logic signed [nsdq_pkg::DitherW-1:0] dither_i,
  output logic signed [nsdq_pkg::CodeW-1:0]   code_o
);
  import nsdq_pkg::*;

  localparam int unsigned RowW = UsedTaps * TapW;

  logic [SetW-1:0]           set;
  logic [RowW-1:0]           row_rd, row_wr;
  logic                      row_we;
  logic [MaxChannels-1:0]    tvld_q, tvld_d;

  // Stage B
  logic signed [SampleW-1:0] sample_b_q;
  logic                      rvld_b_q;
  logic signed [TapW-1:0]    taps_b [UsedTaps];
  logic signed [ProdW-1:0]   prod_b [UsedTaps];
  logic signed [XProdW-1:0]  xprod_b;

  // Stage C
  logic signed [ProdW-1:0]   prod_c_q [UsedTaps];
  logic signed [XProdW-1:0]  xprod_c_q;
  logic signed [DitherW-1:0] dith_c_q;
  logic signed [TapW-1:0]    taps_c_q [UsedTaps-1];
  logic signed [PSumW-1:0]   psum_c [NumGroups];
  logic signed [XProdW-1:0]  xrnd_c;

  // Stage D
  logic signed [PSumW-1:0]   psum_d_q [NumGroups];
  logic signed [XRndW-1:0]   xr_d_q;
  logic signed [DitherW-1:0] dith_d_q;
  logic signed [TapW-1:0]    taps_d_q [UsedTaps-1];
  logic signed [AccW-1:0]    acc_d, acc_rnd;
  logic signed [ShW-1:0]     shaped_d;

  // Stage E
  logic signed [ShW-1:0]     sh_e_q;
  logic signed [DitherW-1:0] dith_e_q;
  logic signed [TapW-1:0]    taps_e_q [UsedTaps-1];
  logic signed [TotW-1:0]    tot_e, err_e, full_t;
  logic signed [FullW-1:0]   full, cl_e, cl_rnd;
  logic signed [TapW-1:0]    errc_e;

  always_comb begin
    case (mode_i)
      ModeShaped9: set = SetW'(1);
      ModeUltra:   set = SetW'(2);
      default:     set = SetW'(0);
    endcase
  end

  // Row valid bits: a row never written reads as zero
  always_comb begin
    tvld_d = tvld_q;
    if (clear_i) begin
      tvld_d = '0;
    end else if (row_we) begin
      tvld_d[ch_e_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvld_q <= '0;
    end else begin
      tvld_q <= tvld_d;
    end
  end

  assign row_we = ctl_i.move_o && shaped_i;

  nsdq_ram #(
    .Width(RowW),
    .Depth(MaxChannels)
  ) u_tap_ram (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(ch_e_i),
    .wdata_i(row_wr),
    .re_i   (ctl_i.accept),
    .raddr_i(ch_i),
    .rdata_o(row_rd)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      sample_b_q <= sample_i;
      rvld_b_q <= tvld_q[ch_i] && shaped_i;
    end
  end

  // Stage B: tap products and input scaling
  always_comb begin
    for (int t = 0; t < UsedTaps; t++) begin
      taps_b[t] = rvld_b_q ? $signed(row_rd[t*TapW +: TapW]) : '0;
      prod_b[t] = taps_b[t] * CoefTable[set][t];
    end
    xprod_b = sample_b_q * $signed({1'b0, m_i});
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.move_b) begin
      prod_c_q <= prod_b;
      xprod_c_q <= xprod_b;
      dith_c_q <= dither_i;
      for (int t = 0; t < UsedTaps - 1; t++) begin
        taps_c_q[t] <= taps_b[t];
      end
    end
  end

  // Stage C: partial sums of three, round the scaled input
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      psum_c[g] = '0;
      for (int k = 0; k < 3; k++) begin
        if (3 * g + k < UsedTaps) begin
          psum_c[g] = psum_c[g] + PSumW'(prod_c_q[3*g+k]);
        end
      end
    end
    xrnd_c = xprod_c_q + (xprod_c_q[XProdW-1] ? XProdW'(1023) : XProdW'(1024));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.move_c) begin
      psum_d_q <= psum_c;
      xr_d_q <= $signed(xrnd_c[XProdW-1:XShift]);
      dith_d_q <= dith_c_q;
      taps_d_q <= taps_c_q;
    end
  end

  // Stage D: close the feedback sum, round it and add the input
  always_comb begin
    acc_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      acc_d = acc_d + AccW'(psum_d_q[g]);
    end
    acc_rnd = acc_d + (acc_d[AccW-1] ? AccW'(8191) : AccW'(8192));
    shaped_d = ShW'(xr_d_q) + ShW'($signed(acc_rnd[AccW-1:CoefFrac]));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.move_d) begin
      sh_e_q <= shaped_d;
      dith_e_q <= dith_d_q;
      taps_e_q <= taps_d_q;
    end
  end

  // Stage E: add dither, clamp to full scale, round to a code, form the error
  always_comb begin
    full = $signed({1'b0, m_i, FracBits'(0)});
    full_t = TotW'(full);
    tot_e = TotW'(sh_e_q) + TotW'(dith_e_q);
    if (tot_e > full_t) begin
      cl_e = full;
    end else if (tot_e < -full_t) begin
      cl_e = -full;
    end else begin
      cl_e = FullW'(tot_e);
    end
    cl_rnd = cl_e + (cl_e[FullW-1] ? FullW'(32767) : FullW'(32768));
    code_o = $signed(cl_rnd[FullW-1:FracBits]);
    err_e = TotW'(sh_e_q) - TotW'($signed({code_o, FracBits'(0)}));
    if (err_e > TotW'(ErrLimit)) begin
      errc_e = TapW'(ErrLimit);
    end else if (err_e < TotW'(-ErrLimit)) begin
      errc_e = TapW'(-ErrLimit);
    end else begin
      errc_e = TapW'(err_e);
    end
  end

  // Shift the history by one place, newest error at tap 0
  always_comb begin
    row_wr[0 +: TapW] = errc_e;
    for (int t = 1; t < UsedTaps; t++) begin
      row_wr[t*TapW +: TapW] = taps_e_q[t-1];
    end
  end

endmodule

/* sv/noise_shaped_dither_quantizer.sv */
// Requantizes an interleaved audio stream (Q5.27 samples, full scale 1.0) to
// 16- or 24-bit codes with triangular dither and optional error-feedback noise
// shaping. One code comes out for every sample, in order. The code passes
// through stages B, C, D and E into an output register. Plain and high-pass
// TPDF modes take a sample every cycle while the output is not held. In the
// shaped modes each channel's error history lives in a tap RAM that is read
// when a sample is taken and written back as its code leaves stage E. A
// sample waits while an earlier sample of the same channel is still in that
// window: throughput is min(1, N/5) samples per cycle for N channels when the
// output is not held. Any write to a known register resets the generator, the
// histories and the channel position; write only when no transaction is in
// flight. Entry valid bits make the state read as zero right after reset, so
// no clearing pass runs.
module noise_shaped_dither_quantizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nsdq_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [nsdq_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [nsdq_pkg::SampleW-1:0] sample_in_i,
  input  logic                                last_in_buffer_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [nsdq_pkg::CodeW-1:0]   code_out_o
);
  import nsdq_pkg::*;

  // Configuration
  logic [ModeW-1:0] mode_q, mode_d;
  logic             w24_q, w24_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             clear;
  logic             shaped, highpass;
  logic [MW-1:0]    m_val;

  // Channel sequencing
  logic [EffW-1:0]  cnt_eff, ch_inc;
  logic [ChW-1:0]   pos_q, pos_d, ch_cur;

  // Pipeline control
  logic             vb_q, vc_q, vd_q, ve_q, ov_q;
  logic             vb_d, vc_d, vd_d, ve_d, ov_d;
  logic [ChW-1:0]   chb_q, chc_q, chd_q, che_q;
  logic             free_b, free_c, free_d, free_e;
  logic             hazard;
  pipe_ctl_t        ctl;

  logic signed [DitherW-1:0] dither_b;
  logic signed [CodeW-1:0]   code_e;
  logic signed [CodeW-1:0]   code_q;

  // Register writes; a write to a known register also resets the generator, the histories and the position
  always_comb begin
    mode_d = mode_q;
    w24_d = w24_q;
    cnt_d = cnt_q;
    clear = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDitherMode: begin
          mode_d = cfg_wdata_i[ModeW-1:0];
          clear = 1'b1;
        end
        CfgWordLength24: begin
          w24_d = cfg_wdata_i[0];
          clear = 1'b1;
        end
        CfgChannelCount: begin
          cnt_d = cfg_wdata_i[CntW-1:0];
          clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign shaped = mode_q inside {ModeShaped5, ModeShaped9, ModeUltra};
  assign highpass = (mode_q == ModeHighpass);
  assign m_val = w24_q ? M24 : M16;

  // Treat a count of zero as one and clamp large counts to the channel limit;
  // restart at channel 0 when the position is out of range
  always_comb begin
    if (cnt_q == '0) begin
      cnt_eff = EffW'(1);
    end else if (32'(cnt_q) > MaxChannels) begin
      cnt_eff = EffW'(MaxChannels);
    end else begin
      cnt_eff = EffW'(cnt_q);
    end
    ch_cur = (EffW'(pos_q) >= cnt_eff) ? '0 : pos_q;
    ch_inc = EffW'(ch_cur) + EffW'(1);
  end

  // Advance from the output backward; a stage moves when the next one frees up
  always_comb begin
    ctl.move_o = ve_q && (!ov_q || out_ready_i);
    free_e = !ve_q || ctl.move_o;
    ctl.move_d = vd_q && free_e;
    free_d = !vd_q || ctl.move_d;
    ctl.move_c = vc_q && free_d;
    free_c = !vc_q || ctl.move_c;
    ctl.move_b = vb_q && free_c;
    free_b = !vb_q || ctl.move_b;
    // Hold a sample whose channel still has a tap-row update in flight
    hazard = shaped && ((vb_q && chb_q == ch_cur) || (vc_q && chc_q == ch_cur) ||
                        (vd_q && chd_q == ch_cur) || (ve_q && che_q == ch_cur));
    in_ready_o = free_b && !hazard;
    ctl.accept = in_valid_i && in_ready_o;
  end

  always_comb begin
    vb_d = ctl.accept || (vb_q && !ctl.move_b);
    vc_d = ctl.move_b || (vc_q && !ctl.move_c);
    vd_d = ctl.move_c || (vd_q && !ctl.move_d);
    ve_d = ctl.move_d || (ve_q && !ctl.move_o);
    ov_d = ctl.move_o || (ov_q && !out_ready_i);
    pos_d = pos_q;
    if (clear) begin
      pos_d = '0;
    end else if (ctl.accept) begin
      if (last_in_buffer_i || ch_inc >= cnt_eff) begin
        pos_d = '0;
      end else begin
        pos_d = ch_inc[ChW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeTpdf;
      w24_q <= 1'b0;
      cnt_q <= CntW'(1);
      pos_q <= '0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      w24_q <= w24_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      vb_q <= vb_d;
      vc_q <= vc_d;
      vd_q <= vd_d;
      ve_q <= ve_d;
      ov_q <= ov_d;
    end
  end

  // Channel tags follow their transactions down the pipe
  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      chb_q <= ch_cur;
    end
    if (ctl.move_b) begin
      chc_q <= chb_q;
    end
    if (ctl.move_c) begin
      chd_q <= chc_q;
    end
    if (ctl.move_d) begin
      che_q <= chd_q;
    end
    if (ctl.move_o) begin
      code_q <= code_e;
    end
  end

  nsdq_dither u_dither (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .clear_i   (clear),
    .highpass_i(highpass),
    .ch_i      (ch_cur),
    .dither_o  (dither_b)
  );

  nsdq_shaper u_shaper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .clear_i (clear),
    .shaped_i(shaped),
    .mode_i  (mode_q),
    .m_i     (m_val),
    .ch_i    (ch_cur),
    .ch_e_i  (che_q),
    .sample_i(sample_in_i),
    .dither_i(dither_b),
    .code_o  (code_e)
  );

  assign out_valid_o = ov_q;
  assign code_out_o = code_q;

endmodule

/* sv/nsdq_checker.sv */
module nsdq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [nsdq_pkg::CodeW-1:0] code_out_o
);
  import nsdq_pkg::*;

  localparam int unsigned Depth = 5;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [CntBits-1:0] inflight_q, inflight_d;

  always_comb begin
    inflight_d = inflight_q;
    if (in_valid_i && in_ready_o) begin
      inflight_d = inflight_d + CntBits'(1);
    end
    if (out_valid_o && out_ready_i) begin
      inflight_d = inflight_d - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // No result without a transaction behind it
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("result presented with no transaction in flight");

  // Never more transactions held than pipeline stages
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntBits'(Depth))
    else $error("more transactions in flight than pipeline stages");

  // Codes are symmetric: the most negative code never appears
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> code_out_o != {1'b1, {(CodeW-1){1'b0}}})
    else $error("code outside full scale");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_out_o))
    else $error("stalled result changed");

endmodule

bind noise_shaped_dither_quantizer nsdq_checker u_nsdq_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import nsdq_pkg::*;

  // Run control
  localparam int DrainCycles = 10;
  localparam int StallLimit  = 2000;  // cycles with no transaction before giving up
  localparam int IdlePct     = 28;    // percent of cycles in which a side idles

  // Codes the block treats as out of range
  localparam logic [CfgIdxW-1:0] CfgUnused     = 2'd3;
  localparam logic [ModeW-1:0]   ModeUndefined = 3'd7;

  // Predictor constants; the error clamp is in LSB units with 16 fractional bits
  localparam logic [31:0] GenSeed   = 32'h6d2b79f5;
  localparam longint      ErrClamp  = 524287;
  localparam longint      Code16Max = 32767;
  localparam longint      Code24Max = 8388607;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i = '0;
  logic [CfgW-1:0]           cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_in_i = '0;
  logic                      last_in_buffer_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [CodeW-1:0]   code_out_o;

  noise_shaped_dither_quantizer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_in_i      (sample_in_i),
    .last_in_buffer_i (last_in_buffer_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_out_o       (code_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  // ---------------------------------------------------------------------------
  // Quantizer predictor: its own copy of the registers and the channel state
  // ---------------------------------------------------------------------------
  logic [ModeW-1:0] mode_reg;
  logic             wl24_reg;
  logic [CntW-1:0]  chan_cnt_reg;

  logic [31:0]      gen_word;
  longint           hp_last_dither [MaxChannels];
  longint           err_hist [MaxChannels][MaxTaps];
  int unsigned      chan_idx;

  // Q2.14 feedback coefficients: shaped5, shaped9, ultra shaped
  int shape_coef [0:2][0:8] = '{
    '{13435, -6226, 3113, -1311, 410, 0, 0, 0, 0},
    '{15565, -8520, 5079, -2949, 1638, -852, 410, -164, 49},
    '{17695, -11141, 7537, -4915, 3113, -1802, 901, -360, 98}
  };

  logic signed [CodeW-1:0] expected_codes [$];
  logic signed [CodeW-1:0] want_code;
  int                      errors = 0;
  logic                    no_idle = 1'b0;
  int                      idle_cycles = 0;

  function automatic longint round_half_away(input longint v, input int unsigned k);
    longint half;
    half = longint'(1) <<< (k - 1);
    if (v >= 0) return (v + half) >>> k;
    return -((-v + half) >>> k);
  endfunction

  // xorshift32, one draw
  function automatic logic [31:0] step_generator();
    logic [31:0] v;
    v = gen_word;
    v ^= v << 13;
    v ^= v >> 17;
    v ^= v << 5;
    gen_word = v;
    return v;
  endfunction

  function automatic void clear_model();
    gen_word = GenSeed;
    chan_idx = 0;
    foreach (hp_last_dither[c]) hp_last_dither[c] = 0;
    foreach (err_hist[c, t]) err_hist[c][t] = 0;
  endfunction

  function automatic logic signed [CodeW-1:0] predict_code(
      input logic signed [SampleW-1:0] s, input logic lst);
    int unsigned cnt, ch, ntaps, set;
    longint      m, full, x, acc, shaped, d, dith, q, err;
    logic [31:0] r1, r2;
    cnt = chan_cnt_reg;
    if (cnt < 1) cnt = 1;
    if (cnt > MaxChannels) cnt = MaxChannels;
    if (chan_idx >= cnt) chan_idx = 0;
    ch = chan_idx;
    ntaps = 0;
    set = 0;
    case (mode_reg)
      ModeShaped5: begin
        set = 0;
        ntaps = 5;
      end
      ModeShaped9: begin
        set = 1;
        ntaps = 9;
      end
      ModeUltra: begin
        set = 2;
        ntaps = 9;
      end
      default: ;
    endcase
    if (ntaps > MaxTaps) ntaps = MaxTaps;
    m = wl24_reg ? Code24Max : Code16Max;
    full = m * 65536;

    // Scale the sample into LSB units and add the filtered error history
    x = round_half_away(longint'(s) * m, 11);
    acc = 0;
    for (int t = 0; t < ntaps; t++) acc += err_hist[ch][t] * longint'(shape_coef[set][t]);
    shaped = x + ((ntaps != 0) ? round_half_away(acc, 14) : 0);

    // Triangular dither from two draws, differenced per channel in high-pass mode
    r1 = step_generator();
    r2 = step_generator();
    d = longint'({16'd0, r1[31:16]}) - longint'({16'd0, r2[31:16]});
    if (mode_reg == ModeHighpass) begin
      dith = round_half_away(d - hp_last_dither[ch], 1);
      hp_last_dither[ch] = d;
    end else begin
      dith = d;
    end

    q = shaped + dith;
    if (q > full) q = full;
    if (q < -full) q = -full;
    q = round_half_away(q, 16);

    // Push the saturated quantization error into this channel's history
    if (ntaps != 0) begin
      for (int t = ntaps - 1; t > 0; t--) err_hist[ch][t] = err_hist[ch][t - 1];
      err = shaped - q * 65536;
      if (err > ErrClamp) err = ErrClamp;
      if (err < -ErrClamp) err = -ErrClamp;
      err_hist[ch][0] = err;
    end

    chan_idx = lst ? 0 : ((ch + 1 >= cnt) ? 0 : ch + 1);
    return q[CodeW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every accepted code against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_codes.size() == 0) begin
        errors++;
        $display("%0t: code %0d with no sample pending, expected none", $time, code_out_o);
      end else begin
        want_code = expected_codes.pop_front();
        if (code_out_o !== want_code) begin
          errors++;
          $display("%0t: code_out mismatch, expected %0d actual %0d",
                   $time, want_code, code_out_o);
        end
      end
    end
  end

  // Receiver: stall at random unless a back-to-back stretch is running
  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  // Watchdog: give up after a long stretch with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("noise_shaped_dither_quantizer verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Write one register; only called with nothing in flight. An unknown index
  // leaves both the registers and the state alone.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    logic known;
    known = 1'b1;
    case (idx)
      CfgDitherMode:   mode_reg = data[ModeW-1:0];
      CfgWordLength24: wl24_reg = data[0];
      CfgChannelCount: chan_cnt_reg = data;
      default:         known = 1'b0;
    endcase
    if (known) clear_model();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send one sample; returns at the edge that accepted it. Valid stays high
  // into the next call unless that call opens an idle gap; each idle cycle is
  // drawn on its own.
  task automatic send_sample(input logic signed [SampleW-1:0] s, input logic lst);
    logic signed [CodeW-1:0] code_exp;
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    code_exp = predict_code(s, lst);
    expected_codes.insert(expected_codes.size(), code_exp);
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    last_in_buffer_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every pending code, then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return r;                                          // anywhere, mostly past clip
      1: return $urandom_range(0, 1) ? 134217728 + int'(r[11:0]) - 2048
                                     : -134217728 + int'(r[11:0]) - 2048;
      2: return int'(r[11:0]) - 2048;                       // near silence
      3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return int'(r[27:0]) - 134217728;            // within full scale
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: plain TPDF, 16 bits, mono; sample extremes
  task automatic test_reset_extremes();
    send_sample(0, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0800_0000, 1'b0);
    send_sample(-32'sh0800_0000, 1'b0);
    send_sample(1, 1'b1);
    send_sample(-1, 1'b0);
    wait_drained();
  endtask

  // One short run per mode, with odd channel counts and register values
  task automatic test_directed_modes();
    // Shaped9, 24 bits, three channels: clip both ways to saturate the error,
    // and end a buffer in the middle of a frame
    cfg_write(CfgDitherMode, CfgW'(ModeShaped9));
    cfg_write(CfgWordLength24, CfgW'(1));
    cfg_write(CfgChannelCount, CfgW'(3));
    send_sample(32'sh07ff_ffff, 1'b0);
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(12345, 1'b1);
    send_sample(-12345, 1'b0);
    send_sample(0, 1'b0);
    wait_drained();

    // High-pass TPDF, stereo
    cfg_write(CfgDitherMode, CfgW'(ModeHighpass));
    cfg_write(CfgWordLength24, CfgW'(0));
    cfg_write(CfgChannelCount, CfgW'(2));
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1000, 1'b0);
    send_sample(-1000, 1'b1);
    wait_drained();

    // Ultra shaped with a channel count above the maximum
    cfg_write(CfgDitherMode, CfgW'(ModeUltra));
    cfg_write(CfgWordLength24, CfgW'(1));
    cfg_write(CfgChannelCount, CfgW'(15));
    send_sample(32'sh0010_0000, 1'b0);
    send_sample(-32'sh0010_0000, 1'b0);
    send_sample(0, 1'b0);
    wait_drained();

    // Shaped5 with a channel count of zero
    cfg_write(CfgDitherMode, CfgW'(ModeShaped5));
    cfg_write(CfgChannelCount, CfgW'(0));
    send_sample(5000, 1'b0);
    send_sample(-5000, 1'b0);
    wait_drained();

    // Undefined mode, stray word-length bits, then a write to no register:
    // the last one must not restart the generator
    cfg_write(CfgDitherMode, {1'b1, ModeUndefined});
    cfg_write(CfgWordLength24, CfgW'(2));
    send_sample(77, 1'b0);
    wait_drained();
    cfg_write(CfgUnused, 4'hf);
    send_sample(-77, 1'b0);
    send_sample(32'sh0400_0000, 1'b1);
    wait_drained();
  endtask

  // Random setups, each followed by buffers, mostly of whole frames, with a little
  // noise on the buffer markers
  task automatic test_random_phases(input int total);
    int   sent, n, eff, buf_len, pos;
    logic planned;
    sent = 0;
    while (sent < total) begin
      cfg_write(CfgDitherMode, ($urandom_range(0, 9) < 8) ? CfgW'($urandom_range(0, 4))
                                                          : CfgW'($urandom_range(0, 15)));
      cfg_write(CfgWordLength24, CfgW'($urandom_range(0, 15)));
      cfg_write(CfgChannelCount, ($urandom_range(0, 3) != 0) ? CfgW'($urandom_range(1, 8))
                                                             : CfgW'($urandom_range(0, 15)));
      if ($urandom_range(0, 7) == 0) cfg_write(CfgUnused, CfgW'($urandom));
      eff = (chan_cnt_reg == 0) ? 1 : ((chan_cnt_reg > MaxChannels) ? MaxChannels : chan_cnt_reg);
      buf_len = ($urandom_range(0, 6) != 0) ? eff * $urandom_range(1, 16) : $urandom_range(1, 40);
      n = $urandom_range(20, 150);
      if (n > total - sent) n = total - sent;
      pos = 0;
      for (int i = 0; i < n; i++) begin
        planned = (pos == buf_len - 1);
        pos = planned ? 0 : pos + 1;
        send_sample(pick_sample(), planned ^ ($urandom_range(0, 49) == 0));
      end
      sent += n;
      wait_drained();
    end
  endtask

  // Full rate with no idling on either side, widest setup
  task automatic test_back_to_back(input int n);
    cfg_write(CfgDitherMode, CfgW'(ModeUltra));
    cfg_write(CfgWordLength24, CfgW'(1));
    cfg_write(CfgChannelCount, CfgW'(MaxChannels));
    no_idle = 1'b1;
    for (int i = 0; i < n; i++) send_sample(pick_sample(), (i % (4 * MaxChannels)) == 31);
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    mode_reg = ModeTpdf;
    wl24_reg = 1'b0;
    chan_cnt_reg = 1;
    clear_model();

    // Hold reset, then release
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_extremes();
    test_directed_modes();
    test_random_phases(1500);
    test_back_to_back(300);

    if (errors == 0) begin
      $display("noise_shaped_dither_quantizer verification clean");
    end else begin
      $display("noise_shaped_dither_quantizer verification failed");
    end
    $finish;
  end

endmodule
